/* design/dsw_pkg.sv */
// package: shared types, bus map constants and the duty pattern lookup
`timescale 1ns / 1ps
package dsw_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef enum logic {
    KIND_READ   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  // decoded control fields of one pulse channel
  typedef struct packed {
    logic [1:0]  duty;
    logic [3:0]  volume;
    logic [10:0] freq;
    logic        trigger;
  } chan_ctrl_t;

  localparam logic [15:0] BASE_ONE    = 16'hFF10;
  localparam logic [15:0] LAST_ONE    = 16'hFF14;
  localparam logic [15:0] BASE_TWO    = 16'hFF16;
  localparam logic [15:0] LAST_TWO    = 16'hFF19;
  localparam logic [15:0] MASTER_ADDR = 16'hFF26;
  localparam logic [7:0]  MASTER_READ = 8'hFF;

  localparam logic [15:0] SAMPLE_PERIOD_RESET = 16'd95;
  localparam logic [11:0] PERIOD_BASE         = 12'd2048;

  localparam int TIMER_W = 14;
  localparam int LEVEL_W = 5;

  // duty pattern bit at a step, step 0 is the msb of the pattern byte
  function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] step);
    logic [7:0] pattern;
    case (duty)
      2'd0:    pattern = 8'b0000_0001;
      2'd1:    pattern = 8'b1000_0001;
      2'd2:    pattern = 8'b1000_0111;
      2'd3:    pattern = 8'b0111_1110;
      default: pattern = 8'b0000_0000;
    endcase
    return pattern[3'd7 - step];
  endfunction

endpackage

/* design/dsw_pulse.sv */
// one pulse channel: period timer, duty position and output level
`timescale 1ns / 1ps
module dsw_pulse (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick,
  input  dsw_pkg::chan_ctrl_t ctrl,
  output logic [3:0]          level
);
  import dsw_pkg::*;

  logic [TIMER_W-1:0] timer;
  logic [TIMER_W-1:0] timer_next;
  logic [TIMER_W-1:0] reload;
  logic [2:0]         step;
  logic [2:0]         step_next;

  always_comb begin
    reload     = {PERIOD_BASE - {1'b0, ctrl.freq}, 2'b00};
    timer_next = timer;
    step_next  = step;
    if (tick) begin
      if (timer == '0) begin
        timer_next = reload - 1'b1;
        step_next  = step + 1'b1;
      end else begin
        timer_next = timer - 1'b1;
      end
    end
  end

  // level after this tick's step update
  assign level = (ctrl.trigger && duty_bit(ctrl.duty, step_next)) ? ctrl.volume : 4'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= '0;
      step  <= '0;
    end else begin
      timer <= timer_next;
      step  <= step_next;
    end
  end

endmodule

/* design/dsw_regfile.sv */
// channel register bytes, bus write decode and read mux
`timescale 1ns / 1ps
module dsw_regfile (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [15:0]         addr,
  input  logic [7:0]          wdata,
  output logic [7:0]          rdata,
  output dsw_pkg::chan_ctrl_t ctrl_one,
  output dsw_pkg::chan_ctrl_t ctrl_two
);
  import dsw_pkg::*;

  logic [7:0]  regs_one [5];
  logic [7:0]  regs_two [4];
  logic        hit_one;
  logic        hit_two;
  logic [15:0] off_one;
  logic [15:0] off_two;
  logic [2:0]  idx_one;
  logic [1:0]  idx_two;

  always_comb begin
    hit_one = (addr >= BASE_ONE) && (addr <= LAST_ONE);
    hit_two = (addr >= BASE_TWO) && (addr <= LAST_TWO);
    off_one = addr - BASE_ONE;
    off_two = addr - BASE_TWO;
    idx_one = off_one[2:0];
    idx_two = off_two[1:0];
  end

  always_comb begin
    if (hit_one) begin
      rdata = regs_one[idx_one];
    end else if (hit_two) begin
      rdata = regs_two[idx_two];
    end else if (addr == MASTER_ADDR) begin
      rdata = MASTER_READ;
    end else begin
      rdata = 8'h00;
    end
  end

  // channel one byte 0 is the sweep register: kept for reads only
  always_comb begin
    ctrl_one.duty    = regs_one[1][7:6];
    ctrl_one.volume  = regs_one[2][7:4];
    ctrl_one.freq    = {regs_one[4][2:0], regs_one[3]};
    ctrl_one.trigger = regs_one[4][7];
    ctrl_two.duty    = regs_two[0][7:6];
    ctrl_two.volume  = regs_two[1][7:4];
    ctrl_two.freq    = {regs_two[3][2:0], regs_two[2]};
    ctrl_two.trigger = regs_two[3][7];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) regs_one[i] <= 8'h00;
      for (int i = 0; i < 4; i++) regs_two[i] <= 8'h00;
    end else if (wr_en) begin
      if (hit_one) begin
        regs_one[idx_one] <= wdata;
      end else if (hit_two) begin
        regs_two[idx_two] <= wdata;
      end
    end
  end

endmodule

/* design/dual_square_wave_sound_unit_top.sv */
// top level: input register, tick and sample timing, result register
`timescale 1ns / 1ps
//
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+-----------------------------------------
// slave    | in  | s_tvalid/s_tready  | s_tuser = cmd, s_tdata = address, write_data
// master   | out | m_tvalid/m_tready  | m_tuser = kind, m_tdata = read_data, levels
// config   | in  | cfg_we             | cfg_wdata = sample_period
//
// one item per cycle sustained while the master side does not stall; an item is
// held in the input register and its result is registered in the output register
// the input register advances when it or the output register is empty or being taken
// rst (synchronous) clears channel registers, timers, duty steps, the sample
// counter and both valid flags, and loads the sample period with 95
// a stall on the master side holds the result and backs up into s_tready
module dual_square_wave_sound_unit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // address [15:0], write_data [23:16]
  input  logic [1:0]  s_tuser,   // cmd [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // read_data [7:0], mixed level [12:8] and again [17:13], zero
  output logic        m_tuser,   // kind [0]
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import dsw_pkg::*;

  // input register
  logic        in_valid;
  logic [1:0]  in_cmd;
  logic [15:0] in_addr;
  logic [7:0]  in_wdata;

  logic        out_ready;
  logic        proc;
  logic        tick_en;
  logic        wr_en;
  logic        rd_en;

  logic [15:0] sample_period;
  logic [15:0] tick_accum;
  logic [15:0] tick_accum_next;
  logic [15:0] period;
  logic [16:0] accum_inc;
  logic [16:0] accum_wrap;
  logic        emit;

  logic [7:0]         rdata;
  chan_ctrl_t         ctrl_one;
  chan_ctrl_t         ctrl_two;
  logic [3:0]         level_one;
  logic [3:0]         level_two;
  logic [LEVEL_W-1:0] level;

  // output register
  logic [7:0]         out_rdata;
  logic [LEVEL_W-1:0] out_level;
  kind_t              out_kind;

  assign out_ready = !m_tvalid || m_tready;
  assign s_tready  = !in_valid || out_ready;
  assign proc      = in_valid && out_ready;

  always_comb begin
    tick_en = 1'b0;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    case (in_cmd)
      CMD_TICK:  tick_en = proc;
      CMD_READ:  rd_en   = proc;
      CMD_WRITE: wr_en   = proc;
      default:   ;  // unused command: dropped
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd   <= s_tuser;
      in_addr  <= s_tdata[15:0];
      in_wdata <= s_tdata[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= SAMPLE_PERIOD_RESET;
    end else if (cfg_we) begin
      sample_period <= cfg_wdata;
    end
  end

  // sample timing: a zero period behaves as one, a shrunk period subtracts once per tick
  always_comb begin
    period          = (sample_period == 16'd0) ? 16'd1 : sample_period;
    accum_inc       = {1'b0, tick_accum} + 17'd1;
    accum_wrap      = accum_inc - {1'b0, period};
    emit            = tick_en && (accum_inc >= {1'b0, period});
    tick_accum_next = tick_accum;
    if (tick_en) begin
      tick_accum_next = emit ? accum_wrap[15:0] : accum_inc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_accum <= 16'd0;
    end else begin
      tick_accum <= tick_accum_next;
    end
  end

  dsw_regfile u_regfile (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .addr     (in_addr),
    .wdata    (in_wdata),
    .rdata    (rdata),
    .ctrl_one (ctrl_one),
    .ctrl_two (ctrl_two)
  );

  dsw_pulse u_pulse_one (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick_en),
    .ctrl  (ctrl_one),
    .level (level_one)
  );

  dsw_pulse u_pulse_two (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick_en),
    .ctrl  (ctrl_two),
    .level (level_two)
  );

  assign level = {1'b0, level_one} + {1'b0, level_two};

  // result register: a read or an emitted sample makes a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= rd_en || emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      out_kind  <= KIND_READ;
      out_rdata <= rdata;
      out_level <= '0;
    end else if (emit) begin
      out_kind  <= KIND_SAMPLE;
      out_rdata <= 8'h00;
      out_level <= level;
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {6'd0, out_level, out_level, out_rdata};

  // a held input item is not lost while the result side stalls
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_ready |=> in_valid && $stable(in_cmd) && $stable(in_addr))
    else $error("input item changed during stall");

  // read results carry no level, sample results carry no read byte
  a_kind_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_READ) ? (m_tdata[17:8] == 10'd0)
                                        : (m_tdata[7:0] == 8'h00))
    else $error("result fields do not match kind");

  // a sample is at most two full volumes
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_SAMPLE) |-> (m_tdata[12:8] <= 5'd30))
    else $error("sample level out of range");

  // results only appear after a processed read or an emitting tick
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(rd_en || emit))
    else $error("result without a cause");

endmodule
